/* rtl/nkwr_pkg.sv */
// ----------------------------------------------------------------------------
// nkwr_pkg
// Types, widths and codes shared by the nearest-within-radius block.
// ----------------------------------------------------------------------------
package nkwr_pkg;

  // Default number of kept objects
  localparam int unsigned MAX_KEPT = 8;

  // Field widths
  localparam int unsigned ID_W   = 16;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned DIST_W = 34;
  localparam int unsigned RANK_W = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_EGO_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EGO_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  // 30 m squared in (1/64 m)^2
  localparam logic [DIST_W-1:0] RADIUS_RESET = 34'd3686400;

  // Input word
  typedef struct packed {
    logic [ID_W-1:0]         object_id;
    logic signed [POS_W-1:0] obj_pos_x;
    logic signed [POS_W-1:0] obj_pos_y;
    logic                    has_object;
    logic                    last_object;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                    found;
    logic [ID_W-1:0]         result_id;
    logic signed [POS_W-1:0] result_pos_x;
    logic signed [POS_W-1:0] result_pos_y;
    logic [DIST_W-1:0]       dist_squared;
    logic [RANK_W-1:0]       rank;
    logic                    last_result;
  } out_word_t;

  // One kept list entry
  typedef struct packed {
    logic [DIST_W-1:0]       dist_sq;
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } entry_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SQR,
    S_SUM,
    S_INS,
    S_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic diff;
    logic square;
    logic sum;
    logic insert;
    logic emit_word;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic item_last;
    logic final_word;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* rtl/nkwr_ctrl.sv */
// ----------------------------------------------------------------------------
// nkwr_ctrl
// Sequencer: steps one item through the distance and insert datapath,
// then walks the kept list out on the result channel.
// ----------------------------------------------------------------------------
module nkwr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  nkwr_pkg::ctrl_sts_t  sts_i,
  output nkwr_pkg::ctrl_cmd_t  cmd_o
);

  nkwr_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nkwr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      nkwr_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = nkwr_pkg::S_DIFF;
        end
      end
      nkwr_pkg::S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = nkwr_pkg::S_SQR;
      end
      nkwr_pkg::S_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = nkwr_pkg::S_SUM;
      end
      nkwr_pkg::S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = nkwr_pkg::S_INS;
      end
      nkwr_pkg::S_INS: begin
        cmd_o.insert = 1'b1;
        state_d      = sts_i.item_last ? nkwr_pkg::S_EMIT : nkwr_pkg::S_IDLE;
      end
      nkwr_pkg::S_EMIT: begin
        // Send one word whenever the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit_word = 1'b1;
          if (sts_i.final_word) begin
            state_d = nkwr_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = nkwr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/nkwr_dpath.sv */
// ----------------------------------------------------------------------------
// nkwr_dpath
// Datapath: config registers, squared-distance pipeline, sorted kept list
// with parallel compare and shift insert, and the result register.
// ----------------------------------------------------------------------------
module nkwr_dpath #(
  parameter int unsigned MAX_KEPT = nkwr_pkg::MAX_KEPT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  nkwr_pkg::in_word_t                  in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [nkwr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nkwr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output nkwr_pkg::out_word_t                 out_data_o,
  input  nkwr_pkg::ctrl_cmd_t                 cmd_i,
  output nkwr_pkg::ctrl_sts_t                 sts_o
);

  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1);

  // Config registers
  logic signed [nkwr_pkg::POS_W-1:0] ego_x_q, ego_y_q;
  logic [nkwr_pkg::DIST_W-1:0]       radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ego_x_q  <= '0;
      ego_y_q  <= '0;
      radius_q <= nkwr_pkg::RADIUS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nkwr_pkg::CFG_EGO_X:  ego_x_q  <= cfg_data_i[nkwr_pkg::POS_W-1:0];
        nkwr_pkg::CFG_EGO_Y:  ego_y_q  <= cfg_data_i[nkwr_pkg::POS_W-1:0];
        nkwr_pkg::CFG_RADIUS: radius_q <= cfg_data_i[nkwr_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Distance pipeline: hold item, differences, squares, sum and radius check
  nkwr_pkg::in_word_t                 item_q;
  logic signed [nkwr_pkg::DIFF_W-1:0] dx_q, dy_q;
  logic signed [nkwr_pkg::DIST_W-1:0] prod_x, prod_y;
  logic [nkwr_pkg::DIST_W-1:0]        sqx_q, sqy_q, dist_q, dist_d;
  logic                               qual_q;

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;
  assign dist_d = sqx_q + sqy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.diff) begin
      dx_q <= nkwr_pkg::DIFF_W'($signed(item_q.obj_pos_x))
            - nkwr_pkg::DIFF_W'($signed(ego_x_q));
      dy_q <= nkwr_pkg::DIFF_W'($signed(item_q.obj_pos_y))
            - nkwr_pkg::DIFF_W'($signed(ego_y_q));
    end
    if (cmd_i.square) begin
      sqx_q <= $unsigned(prod_x);
      sqy_q <= $unsigned(prod_y);
    end
    if (cmd_i.sum) begin
      dist_q <= dist_d;
      qual_q <= item_q.has_object && (dist_d < radius_q);
    end
  end

  // Kept list, sorted nearest first
  nkwr_pkg::entry_t              ent_q [MAX_KEPT];
  nkwr_pkg::entry_t              ent_d [MAX_KEPT];
  nkwr_pkg::entry_t              prev_ent [MAX_KEPT];
  nkwr_pkg::entry_t              next_ent [MAX_KEPT];
  nkwr_pkg::entry_t              new_ent;
  logic [MAX_KEPT-1:0]           le, prev_le;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          empty, final_word;

  assign new_ent.dist_sq = dist_q;
  assign new_ent.id      = item_q.object_id;
  assign new_ent.pos_x   = item_q.obj_pos_x;
  assign new_ent.pos_y   = item_q.obj_pos_y;

  // Per-entry compare and neighbor taps
  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_ent
    assign le[g] = (CNT_W'(g) < cnt_q) && (ent_q[g].dist_sq <= dist_q);
    if (g == 0) begin : g_first
      assign prev_le[g]  = 1'b1;
      assign prev_ent[g] = new_ent;
    end else begin : g_rest
      assign prev_le[g]  = le[g-1];
      assign prev_ent[g] = ent_q[g-1];
    end
    if (g == MAX_KEPT - 1) begin : g_tail
      assign next_ent[g] = ent_q[g];
    end else begin : g_body
      assign next_ent[g] = ent_q[g+1];
    end
  end

  // Insert: keep nearer-or-equal entries, place new one, push the rest down
  // Emit: shift the list toward the head
  always_comb begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      ent_d[i] = ent_q[i];
      if (cmd_i.insert && qual_q) begin
        if (!le[i]) begin
          ent_d[i] = prev_le[i] ? new_ent : prev_ent[i];
        end
      end else if (cmd_i.emit_word) begin
        ent_d[i] = next_ent[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign empty      = (cnt_q == '0);
  assign final_word = (cnt_q <= CNT_W'(1));

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.insert && qual_q && (cnt_q < CNT_W'(MAX_KEPT))) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.emit_word && !empty) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Result register and rank counter
  logic                              out_valid_q, out_valid_d;
  nkwr_pkg::out_word_t               out_q;
  logic [nkwr_pkg::RANK_W-1:0]       rank_q, rank_d;

  always_comb begin
    out_valid_d = out_valid_q;
    rank_d      = rank_q;
    if (cmd_i.emit_word) begin
      out_valid_d = 1'b1;
      rank_d      = final_word ? '0 : rank_q + nkwr_pkg::RANK_W'(1);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rank_q      <= rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_word) begin
      out_q.found        <= !empty;
      out_q.result_id    <= empty ? '0 : ent_q[0].id;
      out_q.result_pos_x <= empty ? '0 : ent_q[0].pos_x;
      out_q.result_pos_y <= empty ? '0 : ent_q[0].pos_y;
      out_q.dist_squared <= empty ? '0 : ent_q[0].dist_sq;
      out_q.rank         <= rank_q;
      out_q.last_result  <= final_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.item_last  = item_q.last_object;
  assign sts_o.final_word = final_word;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

/* rtl/nearest_k_within_radius.sv */
// ----------------------------------------------------------------------------
// nearest_k_within_radius
// Keeps the nearest MAX_KEPT objects inside a squared radius around the ego
// point and sends them nearest first when a set ends.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid_i/in_stall_o | nkwr_pkg::in_word_t
//   out     | output    | out_valid_o/out_stall_i | nkwr_pkg::out_word_t
//   cfg     | input     | cfg_valid_i/cfg_ready_o | index + data, always ready
//
// Each input word goes through load, difference, square, sum with radius
// check, and sorted insert, stepped by the sequencer through one datapath.
// A word marked last then sends max(1, kept) result words, one per cycle
// while out_stall_i is low; input stays stalled until the last one is loaded.
// Reset clears the kept count, the rank counter and the output valid flag;
// the entries need no clearing pass.
// ----------------------------------------------------------------------------
module nearest_k_within_radius #(
  parameter int unsigned MAX_KEPT = nkwr_pkg::MAX_KEPT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  nkwr_pkg::in_word_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output nkwr_pkg::out_word_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nkwr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nkwr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  nkwr_pkg::ctrl_cmd_t cmd;
  nkwr_pkg::ctrl_sts_t sts;

  // Config writes are always accepted and land in the config registers
  assign cfg_ready_o = 1'b1;

  nkwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nkwr_dpath #(
    .MAX_KEPT (MAX_KEPT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* verif/tb_nearest_k_within_radius.sv */
// ----------------------------------------------------------------------------
// tb_nearest_k_within_radius
// Drives object sets into the nearest-within-radius block and checks every
// result word against a local nearest-first list kept per set. Both channels
// idle at random, the configuration is changed between sets, and a watchdog
// ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb_nearest_k_within_radius;

  localparam int unsigned KEEP          = nkwr_pkg::MAX_KEPT;
  localparam int          RANDOM_ITEMS  = 125;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          STUCK_LIMIT   = 5000;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  nkwr_pkg::in_word_t              in_data_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  nkwr_pkg::out_word_t             out_data_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [nkwr_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [nkwr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  nearest_k_within_radius dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Local copy of the block state and configuration
  logic signed [nkwr_pkg::POS_W-1:0] ego_x;
  logic signed [nkwr_pkg::POS_W-1:0] ego_y;
  logic [nkwr_pkg::DIST_W-1:0]       radius_sq;
  nkwr_pkg::entry_t                  kept_list [KEEP];
  int                                kept_total;

  // Result words still owed by the block, oldest first
  nkwr_pkg::out_word_t               owed_results [$];
  int                                fail_count;
  bit                                calm;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Pick an idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic nkwr_pkg::in_word_t make_word(int id, int x, int y, bit has,
                                                   bit last);
    nkwr_pkg::in_word_t w;
    w.object_id   = nkwr_pkg::ID_W'(id);
    w.obj_pos_x   = nkwr_pkg::POS_W'(x);
    w.obj_pos_y   = nkwr_pkg::POS_W'(y);
    w.has_object  = has;
    w.last_object = last;
    return w;
  endfunction

  // Append one result word to the owed list
  function automatic void owe_result(nkwr_pkg::out_word_t r);
    owed_results = {owed_results, r};
  endfunction

  // Insert one object into the sorted list and queue the emission on a last word
  function automatic void predict_word(nkwr_pkg::in_word_t w);
    longint                      dx;
    longint                      dy;
    logic [nkwr_pkg::DIST_W-1:0] d;
    int                          pos;
    int                          top;
    nkwr_pkg::entry_t            e;
    nkwr_pkg::out_word_t         r;
    if (w.has_object) begin
      dx = longint'(w.obj_pos_x) - longint'(ego_x);
      dy = longint'(w.obj_pos_y) - longint'(ego_y);
      d  = nkwr_pkg::DIST_W'(dx * dx + dy * dy);
      if (d < radius_sq) begin
        pos = 0;
        while (pos < kept_total && kept_list[pos].dist_sq <= d) pos++;
        if (pos < KEEP) begin
          top = (kept_total < KEEP) ? kept_total : KEEP - 1;
          for (int i = top; i > pos; i--) kept_list[i] = kept_list[i-1];
          e.dist_sq = d;
          e.id      = w.object_id;
          e.pos_x   = w.obj_pos_x;
          e.pos_y   = w.obj_pos_y;
          kept_list[pos] = e;
          if (kept_total < KEEP) kept_total++;
        end
      end
    end
    if (!w.last_object) return;
    if (kept_total == 0) begin
      r = '0;
      r.last_result = 1'b1;
      owe_result(r);
    end else begin
      for (int k = 0; k < kept_total; k++) begin
        r.found        = 1'b1;
        r.result_id    = kept_list[k].id;
        r.result_pos_x = kept_list[k].pos_x;
        r.result_pos_y = kept_list[k].pos_y;
        r.dist_squared = kept_list[k].dist_sq;
        r.rank         = nkwr_pkg::RANK_W'(k);
        r.last_result  = (k + 1 == kept_total);
        owe_result(r);
      end
    end
    kept_total = 0;
  endfunction

  // Send one input word after a random gap; valid stays up until the next call
  task automatic send_word(nkwr_pkg::in_word_t w);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = w;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(w);
  endtask

  // Drop input valid after the last accepted word
  task automatic end_send();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Hold off until every owed result word has arrived
  task automatic wait_results();
    end_send();
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Bring the block to idle before touching the registers
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [nkwr_pkg::CFG_IDX_W-1:0] idx,
                           logic [nkwr_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      nkwr_pkg::CFG_EGO_X:  ego_x     = value[nkwr_pkg::POS_W-1:0];
      nkwr_pkg::CFG_EGO_Y:  ego_y     = value[nkwr_pkg::POS_W-1:0];
      nkwr_pkg::CFG_RADIUS: radius_sq = value[nkwr_pkg::DIST_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_setting(int x, int y, logic [nkwr_pkg::DIST_W-1:0] r2);
    write_reg(nkwr_pkg::CFG_EGO_X, nkwr_pkg::CFG_DATA_W'(nkwr_pkg::POS_W'(x)));
    write_reg(nkwr_pkg::CFG_EGO_Y, nkwr_pkg::CFG_DATA_W'(nkwr_pkg::POS_W'(y)));
    write_reg(nkwr_pkg::CFG_RADIUS, nkwr_pkg::CFG_DATA_W'(r2));
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result word with the oldest owed one
  initial begin
    nkwr_pkg::out_word_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, actual %p",
                   $time, out_data_o);
        end else begin
          want = owed_results.pop_front();
          check_field("found",        want.found,        out_data_o.found);
          check_field("result_id",    want.result_id,    out_data_o.result_id);
          check_field("result_pos_x", want.result_pos_x, out_data_o.result_pos_x);
          check_field("result_pos_y", want.result_pos_y, out_data_o.result_pos_y);
          check_field("dist_squared", want.dist_squared, out_data_o.dist_squared);
          check_field("rank",         want.rank,         out_data_o.rank);
          check_field("last_result",  want.last_result,  out_data_o.last_result);
        end
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    int hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        hold--;
      end else begin
        out_stall_i = 1'b0;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // End the run if no word moves on any channel for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        stuck = 0;
      else
        stuck++;
    end
    $display("[nearest_k_within_radius] ERROR");
    $finish;
  end

  // Empty set, a bare end marker, an ignored word and the radius boundary
  task automatic test_reset_radius_edge();
    send_word(make_word(0, 0, 0, 1'b0, 1'b1));
    send_word(make_word(0, 0, 0, 1'b1, 1'b0));
    send_word(make_word(16'h1234, 77, -5, 1'b0, 1'b0));
    send_word(make_word(3, 1920, 0, 1'b1, 1'b0));
    send_word(make_word(4, 0, -1919, 1'b1, 1'b1));
    wait_results();
  endtask

  // Farthest corners against extreme ego points and full radius
  task automatic test_coordinate_extremes();
    settle();
    write_setting(-32768, -32768, {nkwr_pkg::DIST_W{1'b1}});
    send_word(make_word(16'hFFFF, 32767, 32767, 1'b1, 1'b0));
    send_word(make_word(0, -32768, -32768, 1'b1, 1'b1));
    settle();
    write_setting(32767, 32767, {nkwr_pkg::DIST_W{1'b1}});
    send_word(make_word(16'hAAAA, -32768, -32768, 1'b1, 1'b0));
    send_word(make_word(0, 0, 0, 1'b0, 1'b1));
  endtask

  // Equal distances keep arrival order; a full list drops ties with the farthest
  task automatic test_ties_and_overflow();
    settle();
    write_setting(0, 0, nkwr_pkg::RADIUS_RESET);
    send_word(make_word(1, 10, 0, 1'b1, 1'b0));
    send_word(make_word(2, 0, 10, 1'b1, 1'b0));
    send_word(make_word(3, 3, 4, 1'b1, 1'b0));
    send_word(make_word(4, -5, 0, 1'b1, 1'b0));
    send_word(make_word(5, 1, 1, 1'b1, 1'b0));
    send_word(make_word(6, 20, 0, 1'b1, 1'b0));
    send_word(make_word(7, 0, -20, 1'b1, 1'b0));
    send_word(make_word(8, 6, 8, 1'b1, 1'b0));
    send_word(make_word(9, -20, 0, 1'b1, 1'b0));
    send_word(make_word(10, 0, 1, 1'b1, 1'b1));
  endtask

  // Zero radius admits nothing, not even an object on the ego point
  task automatic test_zero_radius();
    settle();
    write_setting(100, -100, '0);
    send_word(make_word(11, 100, -100, 1'b1, 1'b0));
    send_word(make_word(12, 101, -100, 1'b1, 1'b1));
  endtask

  // Random sets around random ego points with random radii
  task automatic test_random_sets();
    int sent;
    int set_no;
    int n_obj;
    int spread;
    int ox;
    int oy;
    int px;
    int py;
    int r;
    bit bare_end;
    logic [nkwr_pkg::DIST_W-1:0] r2;
    sent   = 0;
    set_no = 0;
    px     = 0;
    py     = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      // Change the setting every few sets
      if (set_no % 4 == 0) begin
        settle();
        case ($urandom_range(0, 5))
          0:       r2 = '0;
          1:       r2 = {nkwr_pkg::DIST_W{1'b1}};
          2:       r2 = nkwr_pkg::DIST_W'($urandom_range(0, 20000));
          3:       r2 = {2'($urandom), 32'($urandom)};
          default: r2 = nkwr_pkg::DIST_W'($urandom_range(0, 50000000));
        endcase
        case ($urandom_range(0, 3))
          0:       write_setting(-32768, 32767, r2);
          1:       write_setting(32767, -32768, r2);
          default: write_setting($urandom, $urandom, r2);
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 10)      n_obj = 0;
      else if (r < 85) n_obj = $urandom_range(1, 12);
      else             n_obj = $urandom_range(13, 20);
      case ($urandom_range(0, 3))
        0:       spread = 8;
        1:       spread = 200;
        2:       spread = 4000;
        default: spread = 32767;
      endcase
      bare_end = (n_obj == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_obj; i++) begin
        // Mix in words the block ignores
        if ($urandom_range(0, 7) == 0) begin
          send_word(make_word($urandom, $urandom, $urandom, 1'b0, 1'b0));
          sent++;
        end
        if ($urandom_range(0, 5) == 0) begin
          ox = -px;
          oy = py;
        end else begin
          ox = $signed($urandom_range(0, 2 * spread)) - spread;
          oy = $signed($urandom_range(0, 2 * spread)) - spread;
        end
        px = ox;
        py = oy;
        if ($urandom_range(0, 4) == 0)
          send_word(make_word($urandom, $urandom, $urandom, 1'b1,
                              !bare_end && i == n_obj - 1));
        else
          send_word(make_word($urandom, int'(ego_x) + ox, int'(ego_y) + oy, 1'b1,
                              !bare_end && i == n_obj - 1));
        sent++;
      end
      if (bare_end) begin
        send_word(make_word($urandom, $urandom, $urandom, 1'b0, 1'b1));
        sent++;
      end
      // Hold the sender until the whole emission is out
      if (set_no % 5 == 2) wait_results();
      set_no++;
    end
    calm = 1'b0;
  endtask

  // Main sequence
  initial begin
    fail_count  = 0;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    ego_x       = '0;
    ego_y       = '0;
    radius_sq   = nkwr_pkg::RADIUS_RESET;
    kept_total  = 0;
    for (int i = 0; i < KEEP; i++) kept_list[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_radius_edge();
    test_coordinate_extremes();
    test_ties_and_overflow();
    test_zero_radius();
    test_random_sets();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("[nearest_k_within_radius] OK");
    else
      $display("[nearest_k_within_radius] ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/nkwr_pkg.sv
rtl/nkwr_ctrl.sv
rtl/nkwr_dpath.sv
rtl/nearest_k_within_radius.sv
verif/tb_nearest_k_within_radius.sv
